FILE: src/ttsc_pkg.sv
// Shared constants, codes and control structs for the threshold-triggered capture block.
`timescale 1ns / 1ps
package ttsc_pkg;

  localparam int unsigned Depth     = 64;
  localparam int unsigned AddrW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SampleW   = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [SampleW-1:0] TriggerLevelRst = SampleW'(50);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTriggerLevel = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFreeRunning  = 1'b1;

  // input item kinds
  localparam logic InSample = 1'b0;
  localparam logic InRead   = 1'b1;

  // result kinds
  localparam logic [KindW-1:0] KindLive   = 2'd0;
  localparam logic [KindW-1:0] KindStored = 2'd1;
  localparam logic [KindW-1:0] KindNone   = 2'd2;

  typedef struct packed {
    logic             load_live;
    logic             load_stored;
    logic             load_none;
    logic             last;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic above_level;
    logic free_running;
  } dp_stat_t;

endpackage

FILE: src/threshold_triggered_sample_capture_top.sv
// Top level of the threshold-triggered sample capture buffer.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   kind_i, sample_value_i
//   out      output     out_valid_o / out_stall_i result_kind_o, value_o, last_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Samples can enter every cycle while in_stall_o is low.
// A read of a full buffer walks the store with one RAM read port, one entry per
// cycle while the output is not stalled, behind the RAM's registered read data.
// Reset initialises control state, out_valid and the config registers only; the store has no clearing pass.
// A stalled, full output register stalls the input; a readout pauses in place.
`timescale 1ns / 1ps
module threshold_triggered_sample_capture_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttsc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [ttsc_pkg::SampleW-1:0]  sample_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ttsc_pkg::KindW-1:0]    result_kind_o,
  output logic [ttsc_pkg::SampleW-1:0]  value_o,
  output logic                          last_o
);

  ttsc_pkg::ctrl_cmd_t cmd;
  ttsc_pkg::dp_stat_t  stat;

  ttsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .kind_i    (kind_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ttsc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_value_i(sample_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .value_o       (value_o),
    .last_o        (last_o)
  );

endmodule

FILE: src/ttsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ttsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ttsc_dp.sv
// Datapath: configuration registers, threshold compare, capture RAM and output register.
`timescale 1ns / 1ps
module ttsc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ttsc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ttsc_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [ttsc_pkg::SampleW-1:0]     sample_value_i,
  input  ttsc_pkg::ctrl_cmd_t              cmd_i,
  output ttsc_pkg::dp_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ttsc_pkg::KindW-1:0]       result_kind_o,
  output logic [ttsc_pkg::SampleW-1:0]     value_o,
  output logic                             last_o
);

  logic [ttsc_pkg::SampleW-1:0] trig_q;
  logic                         free_q;
  logic                         out_valid_q, out_valid_d;
  logic [ttsc_pkg::KindW-1:0]   kind_q, kind_d;
  logic [ttsc_pkg::SampleW-1:0] val_q, val_d;
  logic                         last_q, last_d;
  logic [ttsc_pkg::SampleW-1:0] rd_data;
  logic                         load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= ttsc_pkg::TriggerLevelRst;
      free_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttsc_pkg::RegTriggerLevel: trig_q <= cfg_data_i[ttsc_pkg::SampleW-1:0];
        ttsc_pkg::RegFreeRunning:  free_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ttsc_ram #(
    .Width(ttsc_pkg::SampleW),
    .Depth(ttsc_pkg::Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.wr_addr),
    .wdata_i(sample_value_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rd_data)
  );

  assign load = cmd_i.load_live | cmd_i.load_stored | cmd_i.load_none;

  always_comb begin
    kind_d = kind_q;
    val_d  = val_q;
    last_d = last_q;
    priority if (cmd_i.load_live) begin
      kind_d = ttsc_pkg::KindLive;
      val_d  = sample_value_i;
      last_d = 1'b1;
    end else if (cmd_i.load_stored) begin
      kind_d = ttsc_pkg::KindStored;
      val_d  = rd_data;
      last_d = cmd_i.last;
    end else if (cmd_i.load_none) begin
      kind_d = ttsc_pkg::KindNone;
      val_d  = '0;
      last_d = 1'b1;
    end else begin
      // no new item: the held one stays
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  assign stat_o.slot_free    = !out_valid_q || !out_stall_i;
  assign stat_o.above_level  = sample_value_i > trig_q;
  assign stat_o.free_running = free_q;

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign value_o       = val_q;
  assign last_o        = last_q;

endmodule

FILE: src/ttsc_ctrl.sv
// Controller: capture/hold state, fill and readout counters, input handshake.
`timescale 1ns / 1ps
module ttsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  ttsc_pkg::dp_stat_t  stat_i,
  output ttsc_pkg::ctrl_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;
  localparam logic [ttsc_pkg::AddrW-1:0] LastIdx = ttsc_pkg::AddrW'(ttsc_pkg::Depth - 1);

  logic                       state_q, state_d;
  logic                       capturing_q, capturing_d;
  logic                       holding_q, holding_d;
  logic [ttsc_pkg::AddrW-1:0] fill_q, fill_d;
  logic [ttsc_pkg::AddrW-1:0] rd_idx_q, rd_idx_d;
  logic                       accept;

  assign in_stall_o = (state_q == StRead) || !stat_i.slot_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    capturing_d = capturing_q;
    holding_d   = holding_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    cmd_o       = '0;
    cmd_o.wr_addr = fill_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (kind_i == ttsc_pkg::InSample) begin
            priority if (capturing_q) begin
              cmd_o.wr_en = 1'b1;
              if (fill_q == LastIdx) begin
                capturing_d = 1'b0;
                holding_d   = 1'b1;
                fill_d      = '0;
              end else begin
                fill_d = fill_q + 1'b1;
              end
            end else if (stat_i.free_running) begin
              cmd_o.load_live = 1'b1;
            end else if (!holding_q && stat_i.above_level) begin
              capturing_d = 1'b1;
              fill_d      = '0;
            end else begin
              // at or below the level, or results held: dropped
            end
          end else begin
            // a read during a capture answers no-results; capture goes on
            if (!capturing_q && holding_q) begin
              holding_d     = 1'b0;
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = '0;
              rd_idx_d      = '0;
              state_d       = StRead;
            end else begin
              cmd_o.load_none = 1'b1;
            end
          end
        end
      end
      StRead: begin
        // RAM data for rd_idx_q sits in its read register; held while stalled
        if (stat_i.slot_free) begin
          cmd_o.load_stored = 1'b1;
          cmd_o.last        = (rd_idx_q == LastIdx);
          if (rd_idx_q == LastIdx) begin
            state_d = StIdle;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = rd_idx_q + 1'b1;
            rd_idx_d      = rd_idx_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      capturing_q <= 1'b0;
      holding_q   <= 1'b0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      capturing_q <= capturing_d;
      holding_q   <= holding_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

endmodule
